@@ sv/rfwd_pkg.sv @@
// Shared types and constants for the ray fan wall distance block.
package rfwd_pkg;

  // Sizes
  localparam int MAX_WALLS  = 16;
  localparam int MAX_RAYS   = 32;
  localparam int COORD_BITS = 16;
  localparam int WALL_AW    = $clog2(MAX_WALLS);

  // Fixed-point constants of the sine series (unsigned Q2.30), the quarter turn and the Q1.14 sine limit
  localparam logic [31:0] Q30_ONE     = 32'd1073741824;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [14:0] QUARTER     = 15'd16384;
  localparam logic [16:0] SIN_MAX     = 17'd16384;

  // Reciprocals for the series divides: n/42 = ((n >> 1) * R42) >> 36,
  // n/20 = (n * R20) >> 36, n/6 = (n * R6) >> 34, exact for 32-bit n
  localparam logic [31:0] SIN_RCP_42  = 32'd3272356036;
  localparam logic [31:0] SIN_RCP_20  = 32'hCCCCCCCD;
  localparam logic [31:0] SIN_RCP_6   = 32'hAAAAAAAB;

  // Parallel wall limit on |D|
  localparam logic signed [35:0] PAR_LIMIT = 36'sd4;

  // Divider sizes
  localparam int DIV_NW    = 50;
  localparam int DIV_DW    = 36;
  localparam int DIV_CNT_W = $clog2(DIV_NW);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAX_RANGE   = 3'd0,
    CFG_WALLS       = 3'd1,
    CFG_RAY_COUNT   = 3'd2,
    CFG_FIRST_OFS   = 3'd3,
    CFG_RAY_SPACING = 3'd4
  } cfg_reg_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } wall_t;

  // Divider request and status
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_stat_t;

endpackage

@@ sv/rfwd_wall_ram.sv @@
// Wall table: 16 entries, one write port, one registered read port.
module rfwd_wall_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [rfwd_pkg::WALL_AW-1:0] waddr,
  input  rfwd_pkg::wall_t         wdata,
  input  logic                    re,
  input  logic [rfwd_pkg::WALL_AW-1:0] raddr,
  output rfwd_pkg::wall_t         rdata
);
  import rfwd_pkg::*;

  wall_t mem [MAX_WALLS];

  // Write one wall
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one wall, data in the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rfwd_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module rfwd_div (
  input  logic                clk,
  input  logic                rst,
  input  rfwd_pkg::div_req_t  req,
  output rfwd_pkg::div_stat_t stat
);
  import rfwd_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NW-1:0]    quo;
  logic [DIV_DW-1:0]    rem;
  logic [DIV_DW-1:0]    dvs;
  logic [DIV_DW:0]      rem_sh;
  logic                 fits;

  assign rem_sh = {rem, quo[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_DW'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[DIV_DW-1:0];
      end
      quo <= {quo[DIV_NW-2:0], fits};
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule

@@ sv/ray_fan_wall_distance_top.sv @@
// Ray fan against a wall table: sequencer, shared multiplier, wall RAM, divider.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | func, wall_slot, wall_*, pose_x/y/heading
//  out     | out_valid/out_stall| ray_number, distance, wall_hit, last_ray
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A store item writes one wall into the table. A cast item computes per ray
// two sine evaluations on the one multiplier (series divides by reciprocal
// products), and per wall in use a RAM read, six products and, when the ray
// can hit it, a 50-step divide that it waits on until it is done.
// Reset is synchronous and clears control state; the wall table is not
// cleared. A stalled result waits in the output register while the next ray
// is computed; the sequencer holds before loading a result into a full one.
module ray_fan_wall_distance_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [3:0]            wall_slot,
  input  logic signed [15:0]    wall_start_x,
  input  logic signed [15:0]    wall_start_y,
  input  logic signed [15:0]    wall_end_x,
  input  logic signed [15:0]    wall_end_y,
  input  logic signed [15:0]    pose_x,
  input  logic signed [15:0]    pose_y,
  input  logic [15:0]           pose_heading,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            ray_number,
  output logic [15:0]           distance,
  output logic                  wall_hit,
  output logic                  last_ray,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import rfwd_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RAY   = 13'b0000000000010,
    S_SMUL  = 13'b0000000000100,
    S_SDIV  = 13'b0000000001000,
    S_SEND  = 13'b0000000010000,
    S_WADDR = 13'b0000000100000,
    S_WREAD = 13'b0000001000000,
    S_WMUL  = 13'b0000010000000,
    S_WCHK  = 13'b0000100000000,
    S_WTEST = 13'b0001000000000,
    S_WDIV  = 13'b0010000000000,
    S_WNEXT = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state;

  // Configuration
  logic [15:0] range_limit;
  logic [4:0]  walls_in_use;
  logic [5:0]  ray_count;
  logic [15:0] first_ray_offset;
  logic [15:0] ray_spacing;

  // Sequencer registers
  logic [4:0]  ray;
  logic [4:0]  wp;
  logic [15:0] nearest;
  logic [5:0]  rays_eff;
  logic [4:0]  walls_eff;
  logic [15:0] ang;
  logic        sel_cos;
  logic [2:0]  sstep;
  logic [2:0]  mstep;
  logic        sneg;
  coord_t      ox;
  coord_t      oy;

  // Sine datapath
  logic [31:0] x;
  logic [31:0] x2;
  logic [31:0] t;
  logic [31:0] s;
  logic [31:0] qn;
  logic [31:0] sq;
  logic signed [15:0] dx;
  logic signed [15:0] dy;

  // Wall datapath
  logic signed [16:0] vx;
  logic signed [16:0] vy;
  logic signed [16:0] wx;
  logic signed [16:0] wy;
  logic signed [35:0] dd;
  logic signed [35:0] tn;
  logic signed [35:0] un;
  logic signed [35:0] prod_r;

  // Multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  // Angle folding
  logic [15:0] sa;
  logic [14:0] arg;

  // Rounding
  logic [32:0] s_rnd;
  logic [16:0] r_raw;
  logic [15:0] r_val;

  // Output load
  logic        load;
  logic        ray_last;

  wall_t       rd_wall;
  wall_t       wr_wall;
  div_req_t    dreq;
  div_stat_t   dstat;

  logic        in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit      <= 16'd2560;
      walls_in_use     <= 5'd4;
      ray_count        <= 6'd19;
      first_ray_offset <= 16'hC000;
      ray_spacing      <= 16'd1820;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RANGE:   range_limit      <= cfg_data;
        CFG_WALLS:       walls_in_use     <= cfg_data[4:0];
        CFG_RAY_COUNT:   ray_count        <= cfg_data[5:0];
        CFG_FIRST_OFS:   first_ray_offset <= cfg_data;
        CFG_RAY_SPACING: ray_spacing      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wall table
  assign wr_wall = '{sx: wall_start_x, sy: wall_start_y, ex: wall_end_x, ey: wall_end_y};

  rfwd_wall_ram u_ram (
    .clk   (clk),
    .we    (in_take && !func),
    .waddr (wall_slot[WALL_AW-1:0]),
    .wdata (wr_wall),
    .re    (state == S_WADDR),
    .raddr (wp[WALL_AW-1:0]),
    .rdata (rd_wall)
  );

  rfwd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .stat (dstat)
  );

  // Fold the angle into the first quadrant
  assign sa  = sel_cos ? ang + 16'h4000 : ang;
  assign arg = sa[14] ? QUARTER - {1'b0, sa[13:0]} : {1'b0, sa[13:0]};

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SMUL: begin
        case (sstep)
          3'd0: begin
            mul_a = {18'b0, arg};
            mul_b = {1'b0, HALF_PI_Q30};
          end
          3'd1: begin
            mul_a = {1'b0, x};
            mul_b = {1'b0, x};
          end
          3'd2, 3'd3: begin
            mul_a = {1'b0, x2};
            mul_b = {1'b0, t};
          end
          default: begin
            mul_a = {1'b0, x};
            mul_b = {1'b0, t};
          end
        endcase
      end
      S_SDIV: begin
        case (sstep)
          3'd1: begin
            mul_a = {2'b0, qn[31:1]};
            mul_b = {1'b0, SIN_RCP_42};
          end
          3'd2: begin
            mul_a = {1'b0, qn};
            mul_b = {1'b0, SIN_RCP_20};
          end
          default: begin
            mul_a = {1'b0, qn};
            mul_b = {1'b0, SIN_RCP_6};
          end
        endcase
      end
      S_WMUL: begin
        case (mstep)
          3'd0: begin
            mul_a = 33'(dx);
            mul_b = 33'(vy);
          end
          3'd1: begin
            mul_a = 33'(dy);
            mul_b = 33'(vx);
          end
          3'd2: begin
            mul_a = 33'(wx);
            mul_b = 33'(vy);
          end
          3'd3: begin
            mul_a = 33'(wy);
            mul_b = 33'(vx);
          end
          3'd4: begin
            mul_a = 33'(wx);
            mul_b = 33'(dy);
          end
          default: begin
            mul_a = 33'(wy);
            mul_b = 33'(dx);
          end
        endcase
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Series quotient from the reciprocal product
  always_comb begin
    case (sstep)
      3'd1, 3'd2: sq = {4'b0, prod[63:36]};
      default:    sq = {2'b0, prod[63:34]};
    endcase
  end

  // Divider requests
  always_comb begin
    dreq = '0;
    if (state == S_WTEST && !(tn < 0 || un < 0 || un > dd)) begin
      dreq.start    = 1'b1;
      dreq.dividend = {tn, 14'b0};
      dreq.divisor  = dd;
    end
  end

  // Round the sine to Q1.14 and clamp
  assign s_rnd = {1'b0, s} + 33'd32768;
  assign r_raw = s_rnd[32:16];
  assign r_val = (r_raw > SIN_MAX) ? 16'(SIN_MAX) : r_raw[15:0];

  assign ray_last = ({1'b0, ray} + 6'd1 == rays_eff);
  assign load     = (state == S_OUT) && (!out_valid || !out_stall);

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ray     <= '0;
      wp      <= '0;
      nearest <= '0;
      sstep   <= '0;
      mstep   <= '0;
      sel_cos <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take && func) begin
            ray <= '0;
            if (ray_count != 6'd0) begin
              state <= S_RAY;
            end
          end
        end
        S_RAY: begin
          sel_cos <= 1'b1;
          sstep   <= '0;
          state   <= S_SMUL;
        end
        S_SMUL: begin
          if (sstep == 3'd0) begin
            sstep <= 3'd1;
          end else if (sstep <= 3'd3) begin
            state <= S_SDIV;
          end else begin
            state <= S_SEND;
          end
        end
        S_SDIV: begin
          sstep <= sstep + 3'd1;
          state <= S_SMUL;
        end
        S_SEND: begin
          sstep <= '0;
          if (sel_cos) begin
            sel_cos <= 1'b0;
            state   <= S_SMUL;
          end else begin
            nearest <= range_limit;
            wp      <= '0;
            state   <= (walls_eff == 5'd0) ? S_OUT : S_WADDR;
          end
        end
        S_WADDR: state <= S_WREAD;
        S_WREAD: begin
          mstep <= '0;
          state <= S_WMUL;
        end
        S_WMUL: begin
          mstep <= mstep + 3'd1;
          if (mstep == 3'd6) begin
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          state <= (dd <= PAR_LIMIT && dd >= -PAR_LIMIT) ? S_WNEXT : S_WTEST;
        end
        S_WTEST: state <= dreq.start ? S_WDIV : S_WNEXT;
        S_WDIV: begin
          if (dstat.done) begin
            if (dstat.quotient < {34'b0, nearest}) begin
              nearest <= dstat.quotient[15:0];
            end
            state <= S_WNEXT;
          end
        end
        S_WNEXT: begin
          if (wp + 5'd1 == walls_eff) begin
            state <= S_OUT;
          end else begin
            wp    <= wp + 5'd1;
            state <= S_WADDR;
          end
        end
        S_OUT: begin
          if (load) begin
            if (ray_last) begin
              ray   <= '0;
              state <= S_IDLE;
            end else begin
              ray   <= ray + 5'd1;
              state <= S_RAY;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (in_take && func) begin
      ox        <= pose_x;
      oy        <= pose_y;
      ang       <= pose_heading + first_ray_offset;
      rays_eff  <= (ray_count > 6'(MAX_RAYS)) ? 6'(MAX_RAYS) : ray_count;
      walls_eff <= (walls_in_use > 5'(MAX_WALLS)) ? 5'(MAX_WALLS) : walls_in_use;
    end
    if (load && !ray_last) begin
      ang <= ang + ray_spacing;
    end
    case (state)
      S_SMUL: begin
        case (sstep)
          3'd0: begin
            x    <= prod[45:14];
            sneg <= sa[15];
          end
          3'd1: begin
            x2 <= prod[61:30];
            qn <= prod[61:30];
          end
          3'd2, 3'd3: qn <= prod[61:30];
          default: s <= prod[61:30];
        endcase
      end
      S_SDIV: begin
        t <= Q30_ONE - sq;
      end
      S_SEND: begin
        if (sel_cos) begin
          dx <= sneg ? -r_val : r_val;
        end else begin
          dy <= sneg ? -r_val : r_val;
        end
      end
      S_WREAD: begin
        vx <= 17'(rd_wall.ex) - 17'(rd_wall.sx);
        vy <= 17'(rd_wall.ey) - 17'(rd_wall.sy);
        wx <= 17'(rd_wall.sx) - 17'(ox);
        wy <= 17'(rd_wall.sy) - 17'(oy);
      end
      S_WMUL: begin
        prod_r <= prod[35:0];
        case (mstep)
          3'd1:    dd <= prod_r;
          3'd2:    dd <= dd - prod_r;
          3'd3:    tn <= prod_r;
          3'd4:    tn <= tn - prod_r;
          3'd5:    un <= prod_r;
          3'd6:    un <= un - prod_r;
          default: ;
        endcase
      end
      S_WCHK: begin
        if (dd < 0) begin
          dd <= -dd;
          tn <= -tn;
          un <= -un;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ray_number <= ray;
      distance   <= nearest;
      wall_hit   <= nearest < range_limit;
      last_ray   <= ray_last;
    end
  end

endmodule

@@ sv/rfwd_checker.sv @@
// Port-level checks for the ray fan wall distance block, bound to the top.
module rfwd_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  ray_number,
  input logic [15:0] distance,
  input logic        last_ray
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ray_number) && $stable(distance))
    else $error("stalled result changed");

  // Results before the last ray come only while a cast is running
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_ray |-> in_stall)
    else $error("input taken in the middle of a fan");

  // A store item leaves the block free in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !func |=> !in_stall)
    else $error("store item held the block");

  // Reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind ray_fan_wall_distance_top rfwd_props u_rfwd_props (.*);
